// ===== rtl/core/positional_integer_list_assert.svh =====
// ----------------------------------------------------------------------------
// positional_integer_list_assert
// assertion macros used by the positional integer list checker
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_INTEGER_LIST_ASSERT_SVH
`define POSITIONAL_INTEGER_LIST_ASSERT_SVH

// property must hold at every clock edge outside reset
`define PIL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// expression must never be true outside reset
`define PIL_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

// ===== rtl/core/pil_pkg.sv =====
// ----------------------------------------------------------------------------
// pil_pkg
// codes and field widths of the positional integer list
// ----------------------------------------------------------------------------
package pil_pkg;

   localparam int DATA_WIDTH   = 32;
   localparam int POS_WIDTH    = 8;
   localparam int ACT_WIDTH    = 2;
   localparam int STATUS_WIDTH = 2;

   typedef enum logic [ACT_WIDTH-1:0] {
      ACT_APPEND = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_REMOVE = 2'd2,
      ACT_READ   = 2'd3
   } action_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

// ===== rtl/core/pil_if.sv =====
// ----------------------------------------------------------------------------
// pil_if
// request and response channels of the positional integer list
// ----------------------------------------------------------------------------
interface pil_req_if
   import pil_pkg::*;
;
   logic                           valid;
   logic                           ready;
   logic [ACT_WIDTH-1:0]           action;
   logic signed [DATA_WIDTH-1:0]   data_value;
   logic [POS_WIDTH-1:0]           item_position;

   modport source (output valid, action, data_value, item_position, input ready);
   modport sink   (input valid, action, data_value, item_position, output ready);
endinterface

interface pil_rsp_if
   import pil_pkg::*;
#(
   parameter int CountWidth = 9
);
   logic                           valid;
   logic                           ready;
   logic signed [DATA_WIDTH-1:0]   read_value;
   logic [CountWidth-1:0]          element_count;
   logic [STATUS_WIDTH-1:0]        status;

   modport source (output valid, read_value, element_count, status, input ready);
   modport sink   (input valid, read_value, element_count, status, output ready);
endinterface

// ===== rtl/core/positional_integer_list.sv =====
// ----------------------------------------------------------------------------
// positional_integer_list
// ordered store of signed integers with append, insert, remove and read
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                  | handshake
//  req_if   | in  | action, data_value, item_position        | valid / ready
//  rsp_if   | out | read_value, element_count, status        | valid / ready
//
//  append and any rejected request go straight to S_DONE; read passes S_RD_WAIT first
//  insert walks S_INS_SHIFT then S_INS_LAST; remove walks S_REM_SHIFT unless p is last
//  the walk moves one element a cycle, one read and one write on the element memory
//  synchronous reset empties the list; memory contents are not cleared
//  a new request is taken while an earlier response waits on rsp_if.ready
//  the request after that holds in its last cycle until the response is taken
// ----------------------------------------------------------------------------
module positional_integer_list
   import pil_pkg::*;
#(
   parameter int CAPACITY = 256
)
(
   input logic         clock,
   input logic         reset,
   pil_req_if.sink     req_if,
   pil_rsp_if.source   rsp_if
);

   localparam int AddrWidth  = $clog2(CAPACITY);
   localparam int CountWidth = $clog2(CAPACITY + 1);
   localparam int CmpWidth   = (CountWidth > POS_WIDTH) ? CountWidth : POS_WIDTH;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_SHIFT,
      S_INS_LAST,
      S_REM_SHIFT,
      S_RD_WAIT,
      S_DONE
   } state_type;

   state_type                      state_ff;
   logic [CountWidth-1:0]          count_ff;
   logic [AddrWidth-1:0]           dst_ff;
   logic [AddrWidth-1:0]           pos_ff;
   logic [DATA_WIDTH-1:0]          value_ff;
   status_type                     status_ff;
   logic [DATA_WIDTH-1:0]          result_ff;

   logic                           rsp_valid_ff;
   logic [DATA_WIDTH-1:0]          rsp_value_ff;
   logic [CountWidth-1:0]          rsp_count_ff;
   status_type                     rsp_status_ff;

   logic [DATA_WIDTH-1:0]          mem [CAPACITY];
   logic [DATA_WIDTH-1:0]          mem_rd_ff;

   logic                           mem_we;
   logic [AddrWidth-1:0]           mem_wa;
   logic [DATA_WIDTH-1:0]          mem_wd;
   logic                           mem_re;
   logic [AddrWidth-1:0]           mem_ra;

   logic                           accept;
   logic                           in_range;
   logic                           full;
   logic [AddrWidth-1:0]           req_pos;
   action_type                     req_action;
   logic                           rem_moves;
   logic                           ins_last;
   logic                           rem_last;
   logic                           rsp_free;

   assign accept     = req_if.valid && (state_ff == S_IDLE);
   assign req_action = action_type'(req_if.action);
   assign req_pos    = AddrWidth'(req_if.item_position);
   assign in_range   = CmpWidth'(req_if.item_position) < CmpWidth'(count_ff);
   assign full       = count_ff == CountWidth'(CAPACITY);
   assign rem_moves  = (CountWidth'(req_pos) + CountWidth'(1)) != count_ff;
   assign ins_last   = dst_ff == (pos_ff + AddrWidth'(1));
   assign rem_last   = (CountWidth'(dst_ff) + CountWidth'(1)) == count_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_if.ready;

   assign req_if.ready         = (state_ff == S_IDLE);
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.read_value    = rsp_value_ff;
   assign rsp_if.element_count = rsp_count_ff;
   assign rsp_if.status        = rsp_status_ff;

   // memory port control
   always_comb begin
      mem_we = 1'b0;
      mem_wa = dst_ff;
      mem_wd = mem_rd_ff;
      mem_re = 1'b0;
      mem_ra = dst_ff - AddrWidth'(2);
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_APPEND: begin
                     mem_we = !full;
                     mem_wa = AddrWidth'(count_ff);
                     mem_wd = req_if.data_value;
                  end
                  ACT_INSERT: begin
                     mem_re = in_range && !full;
                     mem_ra = AddrWidth'(count_ff - CountWidth'(1));
                  end
                  ACT_REMOVE: begin
                     mem_re = in_range;
                     mem_ra = req_pos + AddrWidth'(1);
                  end
                  ACT_READ: begin
                     mem_re = in_range;
                     mem_ra = req_pos;
                  end
                  default: begin
                     mem_re = 1'b0;
                  end
               endcase
            end
         end
         S_INS_SHIFT: begin
            mem_we = 1'b1;
            mem_re = 1'b1;
         end
         S_INS_LAST: begin
            mem_we = 1'b1;
            mem_wa = pos_ff;
            mem_wd = value_ff;
         end
         S_REM_SHIFT: begin
            mem_we = 1'b1;
            mem_re = 1'b1;
            mem_ra = dst_ff + AddrWidth'(2);
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mem_rd_ff <= mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_if.ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  value_ff  <= req_if.data_value;
                  pos_ff    <= req_pos;
                  result_ff <= '0;
                  status_ff <= ST_OK;
                  state_ff  <= S_DONE;
                  case (req_action)
                     ACT_APPEND: begin
                        if (full) begin
                           status_ff <= ST_FULL;
                        end else begin
                           count_ff <= count_ff + CountWidth'(1);
                        end
                     end
                     ACT_INSERT: begin
                        if (!in_range) begin
                           status_ff <= ST_RANGE;
                        end else if (full) begin
                           status_ff <= ST_FULL;
                        end else begin
                           count_ff <= count_ff + CountWidth'(1);
                           dst_ff   <= AddrWidth'(count_ff);
                           state_ff <= S_INS_SHIFT;
                        end
                     end
                     ACT_REMOVE: begin
                        if (!in_range) begin
                           status_ff <= ST_RANGE;
                        end else begin
                           count_ff <= count_ff - CountWidth'(1);
                           dst_ff   <= req_pos;
                           if (rem_moves) begin
                              state_ff <= S_REM_SHIFT;
                           end
                        end
                     end
                     ACT_READ: begin
                        if (!in_range) begin
                           status_ff <= ST_RANGE;
                        end else begin
                           state_ff <= S_RD_WAIT;
                        end
                     end
                     default: begin
                        status_ff <= ST_OK;
                     end
                  endcase
               end
            end
            S_INS_SHIFT: begin
               dst_ff <= dst_ff - AddrWidth'(1);
               if (ins_last) begin
                  state_ff <= S_INS_LAST;
               end
            end
            S_INS_LAST: begin
               state_ff <= S_DONE;
            end
            S_REM_SHIFT: begin
               dst_ff <= dst_ff + AddrWidth'(1);
               if (rem_last) begin
                  state_ff <= S_DONE;
               end
            end
            S_RD_WAIT: begin
               result_ff <= mem_rd_ff;
               state_ff  <= S_DONE;
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_value_ff  <= result_ff;
                  rsp_count_ff  <= count_ff;
                  rsp_status_ff <= status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== rtl/core/pil_checker.sv =====
// ----------------------------------------------------------------------------
// pil_checker
// port-level checks on the responses of the positional integer list
// ----------------------------------------------------------------------------
`include "positional_integer_list_assert.svh"

module pil_checker
   import pil_pkg::*;
#(
   parameter int Capacity = 256
)
(
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [DATA_WIDTH-1:0]          rsp_read_value,
   input logic [$clog2(Capacity + 1)-1:0]       rsp_element_count,
   input logic [STATUS_WIDTH-1:0]               rsp_status
);

   localparam int CountWidth = $clog2(Capacity + 1);

   `PIL_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_element_count) && $stable(rsp_read_value) && $stable(rsp_status), "response changed while stalled")
   `PIL_ASSERT_NEVER(a_count_bound, rsp_valid && (rsp_element_count > CountWidth'(Capacity)), "element count beyond capacity")
   `PIL_ASSERT(a_full_count, rsp_valid && (rsp_status == ST_FULL) |-> rsp_element_count == CountWidth'(Capacity), "full status on a list that is not full")
   `PIL_ASSERT(a_value_ok, rsp_valid && (rsp_read_value != '0) |-> rsp_status == ST_OK, "value returned with a failure status")
   `PIL_ASSERT(a_range_nonempty, rsp_valid && (rsp_status == ST_OK) && (rsp_read_value != '0) |-> rsp_element_count != '0, "read value from an empty list")

endmodule

bind positional_integer_list pil_checker #(
   .Capacity (CAPACITY)
) u_pil_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_read_value    (rsp_if.read_value),
   .rsp_element_count (rsp_if.element_count),
   .rsp_status        (rsp_if.status)
);

// ===== tb/tb_positional_integer_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_integer_list
// self-checking bench for the positional integer list: a queue-fed driver
// and a monitor work the request and response channels under random idling,
// two long response stalls and a full drain, while a behavioural list model
// predicts read value, element count and status for every accepted request
// ----------------------------------------------------------------------------
module tb_positional_integer_list;
   import pil_pkg::*;

   localparam int CAPACITY     = 256;
   localparam int COUNT_WIDTH  = 9;
   localparam int RANDOM_ITEMS = 1325;

   typedef struct {
      action_type                   action;
      logic signed [DATA_WIDTH-1:0] data_value;
      logic [POS_WIDTH-1:0]         item_position;
      bit                           pause;
   } list_req_type;

   typedef struct {
      logic signed [DATA_WIDTH-1:0] read_value;
      logic [COUNT_WIDTH-1:0]       element_count;
      status_type                   status;
   } list_rsp_type;

   typedef enum int {MODE_MIXED, MODE_GROW, MODE_FULL, MODE_SHRINK} fill_mode_type;

   logic clock;
   logic reset;

   pil_req_if req_if ();
   pil_rsp_if #(.CountWidth(COUNT_WIDTH)) rsp_if ();

   positional_integer_list #(.CAPACITY(CAPACITY)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   list_req_type                 pending_req[$];
   list_rsp_type                 expected_rsp[$];
   logic signed [DATA_WIDTH-1:0] list_mem [CAPACITY];
   int                           list_len;
   int                           gen_len;
   int                           req_taken;
   int                           rsp_taken;
   int                           hold_left;
   int                           error_count;

   // gen_len tracks the count the list will have once queued requests are done
   function automatic void add_req(action_type act, logic signed [DATA_WIDTH-1:0] val,
                                   int pos);
      list_req_type r;
      r.action        = act;
      r.data_value    = val;
      r.item_position = pos[POS_WIDTH-1:0];
      r.pause         = 1'b0;
      pending_req.push_back(r);
      case (act)
         ACT_APPEND: if (gen_len < CAPACITY) gen_len++;
         ACT_INSERT: if (pos < gen_len && gen_len < CAPACITY) gen_len++;
         ACT_REMOVE: if (pos < gen_len) gen_len--;
         default: ;
      endcase
   endfunction

   function automatic void add_pause();
      list_req_type r;
      r.action        = ACT_READ;
      r.data_value    = '0;
      r.item_position = '0;
      r.pause         = 1'b1;
      pending_req.push_back(r);
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 19))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return 32'sh0;
         3: return -32'sd1;
         default: return $signed($urandom());
      endcase
   endfunction

   function automatic int pick_pos();
      if (gen_len > 0 && $urandom_range(0, 99) < 88) begin
         return $urandom_range(0, gen_len - 1);
      end
      return $urandom_range(0, 255);
   endfunction

   function automatic action_type pick_action(fill_mode_type mode);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         MODE_GROW: begin
            if (r < 55) return ACT_APPEND;
            else if (r < 80) return ACT_INSERT;
            else if (r < 90) return ACT_READ;
            else return ACT_REMOVE;
         end
         MODE_FULL: begin
            if (r < 35) return ACT_APPEND;
            else if (r < 70) return ACT_INSERT;
            else return ACT_READ;
         end
         MODE_SHRINK: begin
            if (r < 60) return ACT_REMOVE;
            else if (r < 80) return ACT_READ;
            else if (r < 90) return ACT_APPEND;
            else return ACT_INSERT;
         end
         default: begin
            if (r < 28) return ACT_APPEND;
            else if (r < 55) return ACT_INSERT;
            else if (r < 80) return ACT_REMOVE;
            else return ACT_READ;
         end
      endcase
   endfunction

   function automatic list_rsp_type list_apply(action_type act,
                                               logic signed [DATA_WIDTH-1:0] val, int pos);
      list_rsp_type e;
      e.read_value = '0;
      e.status     = ST_OK;
      case (act)
         ACT_APPEND: begin
            if (list_len >= CAPACITY) begin
               e.status = ST_FULL;
            end else begin
               list_mem[list_len] = val;
               list_len++;
            end
         end
         ACT_INSERT: begin
            if (pos >= list_len) begin
               e.status = ST_RANGE;
            end else if (list_len >= CAPACITY) begin
               e.status = ST_FULL;
            end else begin
               for (int i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
               list_mem[pos] = val;
               list_len++;
            end
         end
         ACT_REMOVE: begin
            if (pos >= list_len) begin
               e.status = ST_RANGE;
            end else begin
               for (int i = pos; i < list_len - 1; i++) list_mem[i] = list_mem[i+1];
               list_len--;
            end
         end
         default: begin
            if (pos >= list_len) begin
               e.status = ST_RANGE;
            end else begin
               e.read_value = list_mem[pos];
            end
         end
      endcase
      e.element_count = list_len[COUNT_WIDTH-1:0];
      return e;
   endfunction

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      fill_mode_type mode;
      int            mode_items;
      int            rnd_count;
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.action        = ACT_APPEND;
      req_if.data_value    = '0;
      req_if.item_position = '0;
      rsp_if.ready         = 1'b0;
      list_len             = 0;
      gen_len              = 0;
      error_count          = 0;

      // empty list: nothing is in range, insert cannot add the first element
      add_req(ACT_READ,   '0, 0);
      add_req(ACT_INSERT, 32'sh11111111, 0);
      add_req(ACT_REMOVE, '0, 0);
      add_req(ACT_READ,   '0, 255);
      add_req(ACT_APPEND, 32'sh7fffffff, 0);
      add_req(ACT_APPEND, 32'sh80000000, 0);
      add_req(ACT_APPEND, 32'sh0, 0);
      add_req(ACT_APPEND, -32'sd1, 0);
      add_req(ACT_INSERT, 32'sh12345678, 0);
      add_req(ACT_INSERT, 32'shdeadbeef, 2);
      add_req(ACT_READ,   '0, 0);
      add_req(ACT_READ,   '0, 5);
      // position equal to the count
      add_req(ACT_READ,   '0, 6);
      add_req(ACT_INSERT, 32'sh22222222, 6);
      add_req(ACT_REMOVE, '0, 6);
      add_req(ACT_REMOVE, '0, 5);
      add_req(ACT_REMOVE, '0, 0);
      add_req(ACT_READ,   '0, 0);
      add_req(ACT_READ,   '0, 3);
      add_req(ACT_REMOVE, '0, 2);
      add_req(ACT_READ,   '0, 2);
      add_req(ACT_APPEND, 32'sh5a5a5a5a, 0);
      add_req(ACT_READ,   '0, 255);
      add_req(ACT_INSERT, 32'sh0f0f0f0f, 3);
      add_pause();

      // mixed, then fill to capacity, hold there, drain to empty, mixed again
      mode       = MODE_MIXED;
      mode_items = 0;
      rnd_count  = 0;
      while (rnd_count < RANDOM_ITEMS || mode != MODE_MIXED) begin
         add_req(pick_action(mode), pick_value(), pick_pos());
         rnd_count++;
         mode_items++;
         case (mode)
            MODE_MIXED: if (rnd_count == 300) mode = MODE_GROW;
            MODE_GROW: begin
               if (gen_len == CAPACITY) begin
                  add_pause();
                  mode       = MODE_FULL;
                  mode_items = 0;
               end
            end
            MODE_FULL: if (mode_items == 30) mode = MODE_SHRINK;
            default: if (gen_len == 0) mode = MODE_MIXED;
         endcase
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (pending_req.size() != 0 || expected_rsp.size() != 0 || req_if.valid)
         @(posedge clock);
      repeat (260) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #60_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_taken = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_rsp.push_back(list_apply(action_type'(req_if.action), req_if.data_value,
                                              int'(req_if.item_position)));
            req_taken++;
         end
         if (!(req_if.valid && !req_if.ready)) begin
            // a pause marker holds the sender until every response is in
            if (pending_req.size() != 0 && pending_req[0].pause && expected_rsp.size() == 0)
               void'(pending_req.pop_front());
            if (pending_req.size() == 0 || pending_req[0].pause ||
                (!(req_taken >= 500 && req_taken < 700) && $urandom_range(0, 99) < 29)) begin
               req_if.valid <= 1'b0;
            end else begin
               req_if.valid         <= 1'b1;
               req_if.action        <= pending_req[0].action;
               req_if.data_value    <= pending_req[0].data_value;
               req_if.item_position <= pending_req[0].item_position;
               void'(pending_req.pop_front());
            end
         end
      end
   end

   // response ready, with two long stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left = 0;
         rsp_taken = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_taken++;
            if (rsp_taken == 150 || rsp_taken == 900) hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (rsp_taken >= 500 && rsp_taken < 700) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= 29);
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      list_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_rsp.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_if.read_value !== want.read_value) begin
               $error("read_value: expected %0d, actual %0d", want.read_value,
                      rsp_if.read_value);
               error_count++;
            end
            if (rsp_if.element_count !== want.element_count) begin
               $error("element_count: expected %0d, actual %0d", want.element_count,
                      rsp_if.element_count);
               error_count++;
            end
            if (rsp_if.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
               error_count++;
            end
         end
      end
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/pil_pkg.sv
rtl/core/pil_if.sv
rtl/core/positional_integer_list.sv
rtl/core/pil_checker.sv
tb/tb_positional_integer_list.sv
